@@ rtl/core/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list store package
// Shared sizes and codes for the indexed list store and its channels.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_AT   = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_TAIL = 3'd4,
        OP_DEL_AT   = 3'd5,
        OP_READ     = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

@@ rtl/core/ils_req_if.sv @@
// ----------------------------------------------------------------------------
// Indexed list store request channel
// Valid/ready channel that carries one list operation per transfer.
// ----------------------------------------------------------------------------
interface ils_req_if;

    logic                              valid;
    logic                              ready;
    logic [2:0]                        op;
    logic [ils_pkg::CNT_W-1:0]         position;
    logic signed [ils_pkg::DATA_W-1:0] item_value;

    modport source (output valid, output op, output position, output item_value,
                    input ready);
    modport sink   (input valid, input op, input position, input item_value,
                    output ready);

endinterface

@@ rtl/core/ils_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Indexed list store response channel
// Valid/ready channel that carries one operation result per transfer.
// ----------------------------------------------------------------------------
interface ils_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [ils_pkg::DATA_W-1:0] read_value;
    logic [ils_pkg::CNT_W-1:0]         entry_count;

    modport source (output valid, output status, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input read_value,
                    input entry_count, output ready);

endinterface

@@ rtl/core/indexed_list_store.sv @@
// ----------------------------------------------------------------------------
// Indexed list store
// Ordered list of signed 32-bit values in a single-port-write memory, with
// insert, delete and read at head, tail or index. Entries are moved one at a
// time by a shared read/write step under a small sequencer.
// ----------------------------------------------------------------------------
// Insert shifts the entries from the tail down to the index, then writes the
// new value; delete shifts the later entries down; read is one memory read.
// Each shift step is one memory read followed by one memory write.
// A new request is taken the cycle after the response is loaded; the response
// register lets the next request start while the result waits.
// Reset clears the count and the control state; the memory is not cleared.
module indexed_list_store (
    input  logic      clk,
    input  logic      rst_n,
    ils_req_if.sink   req,
    ils_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_PUT,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INS,
        ACT_DEL,
        ACT_READ
    } act_t;

    state_t                        state_reg;
    act_t                          act_reg;
    ils_pkg::status_t              status_reg;
    logic [ils_pkg::CNT_W-1:0]     count_reg;
    logic [ils_pkg::CNT_W-1:0]     ptr_reg;
    logic [ils_pkg::CNT_W-1:0]     at_reg;
    logic [ils_pkg::DATA_W-1:0]    val_reg;
    logic                          out_valid_reg;
    logic [1:0]                    out_status_reg;
    logic [ils_pkg::DATA_W-1:0]    out_value_reg;
    logic [ils_pkg::CNT_W-1:0]     out_count_reg;

    logic [ils_pkg::DATA_W-1:0]    mem [ils_pkg::CAPACITY];
    logic [ils_pkg::DATA_W-1:0]    rdata_reg;
    logic                          mem_we;
    logic [ils_pkg::ADDR_W-1:0]    mem_waddr;
    logic [ils_pkg::DATA_W-1:0]    mem_wdata;
    logic                          mem_re;
    logic [ils_pkg::CNT_W-1:0]     rd_ptr;

    logic [ils_pkg::CNT_W-1:0]     cap;
    logic                          full;
    logic                          empty;
    logic                          out_free;
    logic                          rsp_load;
    logic [ils_pkg::CNT_W-1:0]     ptr_dec;
    logic [ils_pkg::CNT_W-1:0]     ptr_inc;

    state_t                        dec_state;
    act_t                          dec_act;
    ils_pkg::status_t              dec_status;
    logic [ils_pkg::CNT_W-1:0]     dec_ptr;
    logic [ils_pkg::CNT_W-1:0]     dec_at;

    assign cap      = ils_pkg::CNT_W'(ils_pkg::CAPACITY);
    assign full     = (count_reg >= cap);
    assign empty    = (count_reg == '0);
    assign out_free = !out_valid_reg || rsp.ready;
    assign rsp_load = (state_reg == S_FIN) && out_free;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign ptr_inc  = ptr_reg + 1'b1;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.entry_count = out_count_reg;

    always_comb
    begin
        case (act_reg)
            ACT_INS: rd_ptr = ptr_dec;
            ACT_DEL: rd_ptr = ptr_inc;
            default: rd_ptr = ptr_reg;
        endcase
        mem_re    = (state_reg == S_RD);
        mem_we    = (state_reg == S_WR) || (state_reg == S_PUT);
        mem_waddr = (state_reg == S_PUT) ? at_reg[ils_pkg::ADDR_W-1:0]
                                         : ptr_reg[ils_pkg::ADDR_W-1:0];
        mem_wdata = (state_reg == S_PUT) ? val_reg : rdata_reg;
    end

    always_comb
    begin
        dec_act    = ACT_NONE;
        dec_status = ils_pkg::ST_BAD_INDEX;
        dec_state  = S_FIN;
        dec_ptr    = ptr_reg;
        dec_at     = at_reg;
        case (req.op)
            ils_pkg::OP_INS_HEAD, ils_pkg::OP_INS_TAIL,
            ils_pkg::OP_INS_AT:
            begin
                if ((req.op == ils_pkg::OP_INS_AT) && (req.position > count_reg))
                begin
                    dec_status = ils_pkg::ST_BAD_INDEX;
                end
                else if (full)
                begin
                    dec_status = ils_pkg::ST_FULL;
                end
                else
                begin
                    dec_status = ils_pkg::ST_OK;
                    dec_act    = ACT_INS;
                    dec_ptr    = count_reg;
                    if (req.op == ils_pkg::OP_INS_HEAD)
                    begin
                        dec_at    = '0;
                        dec_state = empty ? S_PUT : S_RD;
                    end
                    else if (req.op == ils_pkg::OP_INS_TAIL)
                    begin
                        dec_at    = count_reg;
                        dec_state = S_PUT;
                    end
                    else
                    begin
                        dec_at    = req.position;
                        dec_state = (req.position == count_reg) ? S_PUT : S_RD;
                    end
                end
            end
            ils_pkg::OP_DEL_HEAD, ils_pkg::OP_DEL_TAIL:
            begin
                if (empty)
                begin
                    dec_status = ils_pkg::ST_EMPTY;
                end
                else
                begin
                    dec_status = ils_pkg::ST_OK;
                    dec_act    = ACT_DEL;
                    if (req.op == ils_pkg::OP_DEL_HEAD)
                    begin
                        dec_ptr   = '0;
                        dec_state = (count_reg > ils_pkg::CNT_W'(1)) ? S_RD : S_FIN;
                    end
                    else
                    begin
                        dec_ptr   = count_reg - 1'b1;
                        dec_state = S_FIN;
                    end
                end
            end
            ils_pkg::OP_DEL_AT:
            begin
                if (req.position < count_reg)
                begin
                    dec_status = ils_pkg::ST_OK;
                    dec_act    = ACT_DEL;
                    dec_ptr    = req.position;
                    dec_state  = ((req.position + 1'b1) < count_reg) ? S_RD : S_FIN;
                end
            end
            ils_pkg::OP_READ:
            begin
                if (req.position < count_reg)
                begin
                    dec_status = ils_pkg::ST_OK;
                    dec_act    = ACT_READ;
                    dec_ptr    = req.position;
                    dec_state  = S_RD;
                end
            end
            default:
            begin
                dec_status = ils_pkg::ST_BAD_INDEX;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_ptr[ils_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= ACT_NONE;
            status_reg     <= ils_pkg::ST_OK;
            count_reg      <= '0;
            ptr_reg        <= '0;
            at_reg         <= '0;
            val_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ils_pkg::ST_OK;
            out_value_reg  <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        val_reg    <= req.item_value;
                        act_reg    <= dec_act;
                        status_reg <= dec_status;
                        state_reg  <= dec_state;
                        ptr_reg    <= dec_ptr;
                        at_reg     <= dec_at;
                    end
                end
                S_RD:
                begin
                    state_reg <= (act_reg == ACT_READ) ? S_FIN : S_WR;
                end
                S_WR:
                begin
                    if (act_reg == ACT_INS)
                    begin
                        ptr_reg   <= ptr_dec;
                        state_reg <= (ptr_dec == at_reg) ? S_PUT : S_RD;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_inc;
                        state_reg <= ((ptr_inc + 1'b1) < count_reg) ? S_RD : S_FIN;
                    end
                end
                S_PUT:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= status_reg;
                        out_value_reg  <= (act_reg == ACT_READ) ? rdata_reg : '0;
                        case (act_reg)
                            ACT_INS:
                            begin
                                count_reg     <= count_reg + 1'b1;
                                out_count_reg <= count_reg + 1'b1;
                            end
                            ACT_DEL:
                            begin
                                count_reg     <= count_reg - 1'b1;
                                out_count_reg <= count_reg - 1'b1;
                            end
                            default:
                            begin
                                out_count_reg <= count_reg;
                            end
                        endcase
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap)
        else $error("entry count above capacity");

    // A pending response always reports the count the store holds now.
    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.entry_count == count_reg))
        else $error("response count differs from stored count");

    // Only a successful read carries a nonzero value.
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.read_value != '0)) |-> (rsp.status == ils_pkg::ST_OK))
        else $error("nonzero read value with error status");

    // Every memory write lands below the current count plus one.
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ({1'b0, mem_waddr} <= count_reg))
        else $error("memory write beyond list end");

endmodule
